/* rtl/fped_pkg.sv */
package fped_pkg;

   // Time arithmetic width (wraps modulo 2**TIME_BITS)
   localparam int TIME_BITS = 32;

   localparam int SAMPLE_BITS    = 8;
   localparam int STAMP_BITS     = 32;
   localparam int COUNT_BITS     = 32;
   localparam int WINDOW_DEPTH   = 5;
   localparam int SLOT_BITS      = $clog2(WINDOW_DEPTH);
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 16;

   // filter modes
   localparam logic [1:0] MODE_MEAN3 = 2'd0;
   localparam logic [1:0] MODE_MED3  = 2'd1;
   localparam logic [1:0] MODE_MED5  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_FILTER_MODE = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RISE_STEP   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PULSE_WIDTH = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WIDTH_TOL   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TIMEOUT     = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SETTLE      = 3'd5;

   // register reset values
   localparam logic [1:0]  RST_FILTER_MODE = MODE_MED5;
   localparam logic [6:0]  RST_RISE_STEP   = 7'd10;
   localparam logic [7:0]  RST_PULSE_WIDTH = 8'd10;
   localparam logic [7:0]  RST_WIDTH_TOL   = 8'd2;
   localparam logic [7:0]  RST_TIMEOUT     = 8'd50;
   localparam logic [15:0] RST_SETTLE      = 16'd100;

   // floor(x/3) = (x*683) >> 11, exact for x <= 765
   localparam logic [9:0] MEAN3_RECIP = 10'd683;
   localparam int         MEAN3_SHIFT = 11;

   typedef logic [WINDOW_DEPTH-1:0][SAMPLE_BITS-1:0] window_type;

   typedef struct packed {
      logic [1:0]  filter_mode;
      logic [6:0]  rise_step;
      logic [7:0]  pulse_width_ms;
      logic [7:0]  width_tolerance_ms;
      logic [7:0]  timeout_ms;
      logic [15:0] settle_ms;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] filtered_value;
      logic                   pulse_found;
      logic                   pulse_complete;
      logic [COUNT_BITS-1:0]  pulse_number;
      logic [STAMP_BITS-1:0]  report_time;
      logic [SAMPLE_BITS-1:0] before_rise;
      logic [SAMPLE_BITS-1:0] after_rise;
      logic [SAMPLE_BITS-1:0] before_fall;
      logic [SAMPLE_BITS-1:0] after_fall;
   } result_type;

   // compare-exchange: returns {low, high}
   function automatic logic [2*SAMPLE_BITS-1:0] cmpx(input logic [SAMPLE_BITS-1:0] a,
                                                     input logic [SAMPLE_BITS-1:0] b);
      return (a > b) ? {b, a} : {a, b};
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] median3(input logic [SAMPLE_BITS-1:0] a,
                                                      input logic [SAMPLE_BITS-1:0] b,
                                                      input logic [SAMPLE_BITS-1:0] c);
      logic [SAMPLE_BITS-1:0] lo_ab;
      logic [SAMPLE_BITS-1:0] hi_ab;
      logic [SAMPLE_BITS-1:0] mid_c;
      {lo_ab, hi_ab} = cmpx(a, b);
      mid_c = (hi_ab < c) ? hi_ab : c;
      return (lo_ab > mid_c) ? lo_ab : mid_c;
   endfunction

   // nine-comparator sorting network, middle element taken
   function automatic logic [SAMPLE_BITS-1:0] median5(input window_type w);
      window_type s;
      s = w;
      {s[0], s[1]} = cmpx(s[0], s[1]);
      {s[3], s[4]} = cmpx(s[3], s[4]);
      {s[2], s[4]} = cmpx(s[2], s[4]);
      {s[2], s[3]} = cmpx(s[2], s[3]);
      {s[0], s[3]} = cmpx(s[0], s[3]);
      {s[0], s[2]} = cmpx(s[0], s[2]);
      {s[1], s[4]} = cmpx(s[1], s[4]);
      {s[1], s[3]} = cmpx(s[1], s[3]);
      {s[1], s[2]} = cmpx(s[1], s[2]);
      return s[2];
   endfunction

endpackage

/* rtl/fped_if.sv */
interface fped_req_if;
   logic                              valid;
   logic                              ready;
   logic [fped_pkg::SAMPLE_BITS-1:0]  sample;
   logic [fped_pkg::STAMP_BITS-1:0]   sample_time;

   modport source (output valid, sample, sample_time, input ready);
   modport sink   (input valid, sample, sample_time, output ready);
endinterface

interface fped_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [fped_pkg::SAMPLE_BITS-1:0]  filtered_value;
   logic                              pulse_found;
   logic                              pulse_complete;
   logic [fped_pkg::COUNT_BITS-1:0]   pulse_number;
   logic [fped_pkg::STAMP_BITS-1:0]   report_time;
   logic [fped_pkg::SAMPLE_BITS-1:0]  before_rise;
   logic [fped_pkg::SAMPLE_BITS-1:0]  after_rise;
   logic [fped_pkg::SAMPLE_BITS-1:0]  before_fall;
   logic [fped_pkg::SAMPLE_BITS-1:0]  after_fall;

   modport source (output valid, filtered_value, pulse_found, pulse_complete, pulse_number,
                   report_time, before_rise, after_rise, before_fall, after_fall,
                   input ready);
   modport sink   (input valid, filtered_value, pulse_found, pulse_complete, pulse_number,
                   report_time, before_rise, after_rise, before_fall, after_fall,
                   output ready);
endinterface

interface fped_csr_if;
   logic                               valid;
   logic                               ready;
   logic [fped_pkg::CSR_IDX_BITS-1:0]  index;
   logic [fped_pkg::CSR_DATA_BITS-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/fped_filter.sv */
module fped_filter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic [1:0]                       filter_mode,
   input  logic [fped_pkg::SAMPLE_BITS-1:0] sample,
   output logic [fped_pkg::SAMPLE_BITS-1:0] filtered
);

   fped_pkg::window_type                window_ff;
   fped_pkg::window_type                window_in;
   logic [fped_pkg::SLOT_BITS-1:0]      slot_ff;
   logic [fped_pkg::SLOT_BITS-1:0]      slot_in;
   logic [fped_pkg::SLOT_BITS-1:0]      win_len;
   logic [fped_pkg::SLOT_BITS-1:0]      wr_slot;
   logic [fped_pkg::SLOT_BITS-1:0]      wr_next;
   logic [fped_pkg::SAMPLE_BITS+1:0]    sum3;
   logic [fped_pkg::SAMPLE_BITS+11:0]   prod3;

   // a slot left over from five-sample mode restarts at entry 0
   always_comb begin
      win_len = (filter_mode == fped_pkg::MODE_MED5) ? fped_pkg::SLOT_BITS'(5)
                                                      : fped_pkg::SLOT_BITS'(3);
      wr_slot = (slot_ff < win_len) ? slot_ff : '0;
      wr_next = wr_slot + fped_pkg::SLOT_BITS'(1);
      slot_in = (wr_next == win_len) ? '0 : wr_next;
      window_in = window_ff;
      window_in[wr_slot] = sample;
   end

   always_comb begin
      sum3  = 10'(window_in[0]) + 10'(window_in[1]) + 10'(window_in[2]);
      prod3 = 20'(sum3) * 20'(fped_pkg::MEAN3_RECIP);
      case (filter_mode)
         fped_pkg::MODE_MED5: filtered = fped_pkg::median5(window_in);
         fped_pkg::MODE_MED3: filtered = fped_pkg::median3(window_in[0], window_in[1],
                                                           window_in[2]);
         default:             filtered = prod3[fped_pkg::MEAN3_SHIFT +: fped_pkg::SAMPLE_BITS];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         slot_ff   <= '0;
      end else if (advance) begin
         window_ff <= window_in;
         slot_ff   <= slot_in;
      end
   end

endmodule

/* rtl/fped_detect.sv */
module fped_detect (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  fped_pkg::cfg_type                cfg,
   input  logic [fped_pkg::SAMPLE_BITS-1:0] filtered,
   input  logic [fped_pkg::STAMP_BITS-1:0]  sample_time,
   output fped_pkg::result_type             result
);

   localparam int TB = fped_pkg::TIME_BITS;
   localparam int SB = fped_pkg::SAMPLE_BITS;

   logic [SB-1:0]                   prev_ff;
   logic [SB-1:0]                   prev_in;
   logic                            in_pulse_ff;
   logic                            in_pulse_in;
   logic [TB-1:0]                   rise_time_ff;
   logic [TB-1:0]                   rise_time_in;
   logic [SB-1:0]                   held_before_ff;
   logic [SB-1:0]                   held_before_in;
   logic [SB-1:0]                   held_after_ff;
   logic [SB-1:0]                   held_after_in;
   logic [fped_pkg::COUNT_BITS-1:0] count_ff;
   logic [fped_pkg::COUNT_BITS-1:0] count_in;

   logic [TB-1:0] now;
   logic [TB-1:0] elapsed;
   logic [TB-1:0] pw;
   logic [TB-1:0] dev;
   logic          settling;
   logic          rise;
   logic          fall_ok;
   logic          timed_out;
   logic          found;

   always_comb begin
      now      = TB'(sample_time);
      settling = now < TB'(cfg.settle_ms);
      rise     = !in_pulse_ff &&
                 ({1'b0, filtered} > ({1'b0, prev_ff} + (SB+1)'(cfg.rise_step)));
      elapsed  = now - rise_time_ff;
      pw       = TB'(cfg.pulse_width_ms);
      dev      = (elapsed >= pw) ? elapsed - pw : pw - elapsed;
      fall_ok  = in_pulse_ff && (dev <= TB'(cfg.width_tolerance_ms)) &&
                 ({1'b0, prev_ff} > ({1'b0, filtered} + (SB+1)'(cfg.rise_step >> 1)));
      timed_out = in_pulse_ff && (elapsed > TB'(cfg.timeout_ms));
      found    = !settling && (fall_ok || timed_out);
   end

   always_comb begin
      prev_in        = filtered;
      in_pulse_in    = in_pulse_ff;
      rise_time_in   = rise_time_ff;
      held_before_in = held_before_ff;
      held_after_in  = held_after_ff;
      count_in       = count_ff;
      if (!settling && rise) begin
         in_pulse_in    = 1'b1;
         rise_time_in   = now;
         held_before_in = prev_ff;
         held_after_in  = filtered;
      end
      if (found) begin
         in_pulse_in = 1'b0;
         count_in    = count_ff + fped_pkg::COUNT_BITS'(1);
      end
   end

   always_comb begin
      result                = '0;
      result.filtered_value = filtered;
      if (found) begin
         result.pulse_found    = 1'b1;
         result.pulse_complete = fall_ok;
         result.pulse_number   = count_ff;
         result.report_time    = fped_pkg::STAMP_BITS'(now);
         result.before_rise    = held_before_ff;
         result.after_rise     = held_after_ff;
         result.before_fall    = prev_ff;
         result.after_fall     = filtered;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff        <= '0;
         in_pulse_ff    <= 1'b0;
         rise_time_ff   <= '0;
         held_before_ff <= '0;
         held_after_ff  <= '0;
         count_ff       <= '0;
      end else if (advance) begin
         prev_ff        <= prev_in;
         in_pulse_ff    <= in_pulse_in;
         rise_time_ff   <= rise_time_in;
         held_before_ff <= held_before_in;
         held_after_ff  <= held_after_in;
         count_ff       <= count_in;
      end
   end

endmodule

/* rtl/filtered_pulse_edge_detector.sv */
// Filtered pulse edge detector. Each request carries one 8-bit light-sensor sample and its
// millisecond timestamp and yields exactly one response, in request order: the filtered
// value (mean of three, median of three or median of five, by filter_mode) and, when that
// sample closes a pulse, a pulse report (completed by a fall inside the expected width
// window, or timed out); with no report all report fields read zero. One request can be
// taken every cycle: a request is latched in an input register, filtered and checked
// against the pulse state in a single pass into the output register, and its response is
// valid on rsp from the output register once the request has advanced into it. A response
// held on rsp stalls the input register, and once that register is full the request side
// stalls too. The window, pulse state and report counter clear on reset, and the
// registers return to their defaults (median of five, step 10, width 10 ms, tolerance
// 2 ms, timeout 50 ms, settle 100 ms). Write registers through csr only while no request
// is in flight; csr writes complete in the cycle they are offered, and writes to indexes
// beyond settle_ms are dropped.
module filtered_pulse_edge_detector (
   input  logic             clock,
   input  logic             reset,
   fped_req_if.sink         req,
   fped_rsp_if.source       rsp,
   fped_csr_if.sink         csr
);

   fped_pkg::cfg_type                cfg_ff;
   fped_pkg::cfg_type                cfg_in;

   logic                             s1_valid_ff;
   logic                             s1_valid_in;
   logic [fped_pkg::SAMPLE_BITS-1:0] s1_sample_ff;
   logic [fped_pkg::STAMP_BITS-1:0]  s1_time_ff;

   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   fped_pkg::result_type             rsp_data_ff;
   fped_pkg::result_type             rsp_data_in;

   logic                             req_take;
   logic                             advance;
   logic [fped_pkg::SAMPLE_BITS-1:0] filtered;

   // Configuration: always ready, decode the index, drop unknown indexes.
   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.index)
            fped_pkg::CSR_FILTER_MODE: cfg_in.filter_mode        = csr.data[1:0];
            fped_pkg::CSR_RISE_STEP:   cfg_in.rise_step          = csr.data[6:0];
            fped_pkg::CSR_PULSE_WIDTH: cfg_in.pulse_width_ms     = csr.data[7:0];
            fped_pkg::CSR_WIDTH_TOL:   cfg_in.width_tolerance_ms = csr.data[7:0];
            fped_pkg::CSR_TIMEOUT:     cfg_in.timeout_ms         = csr.data[7:0];
            fped_pkg::CSR_SETTLE:      cfg_in.settle_ms          = csr.data[15:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_mode        <= fped_pkg::RST_FILTER_MODE;
         cfg_ff.rise_step          <= fped_pkg::RST_RISE_STEP;
         cfg_ff.pulse_width_ms     <= fped_pkg::RST_PULSE_WIDTH;
         cfg_ff.width_tolerance_ms <= fped_pkg::RST_WIDTH_TOL;
         cfg_ff.timeout_ms         <= fped_pkg::RST_TIMEOUT;
         cfg_ff.settle_ms          <= fped_pkg::RST_SETTLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Advance the input register into the output register whenever the output
   // register is empty or its response is being taken this cycle.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || advance;
   assign req_take  = req.valid && req.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Hold the latched request until it advances.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_sample_ff <= req.sample;
         s1_time_ff   <= req.sample_time;
      end
   end

   fped_filter u_filter (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .filter_mode (cfg_ff.filter_mode),
      .sample      (s1_sample_ff),
      .filtered    (filtered)
   );

   fped_detect u_detect (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .cfg         (cfg_ff),
      .filtered    (filtered),
      .sample_time (s1_time_ff),
      .result      (rsp_data_in)
   );

   // Output register: load on advance, drop valid once the response is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.filtered_value = rsp_data_ff.filtered_value;
   assign rsp.pulse_found    = rsp_data_ff.pulse_found;
   assign rsp.pulse_complete = rsp_data_ff.pulse_complete;
   assign rsp.pulse_number   = rsp_data_ff.pulse_number;
   assign rsp.report_time    = rsp_data_ff.report_time;
   assign rsp.before_rise    = rsp_data_ff.before_rise;
   assign rsp.after_rise     = rsp_data_ff.after_rise;
   assign rsp.before_fall    = rsp_data_ff.before_fall;
   assign rsp.after_fall     = rsp_data_ff.after_fall;

`ifndef SYNTHESIS
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_sample_ff) && $stable(s1_time_ff))
      else $error("latched request lost or changed while stalled");

   a_advance_loads: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced request produced no response");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req.ready)
      else $error("input register empty but request refused");

   a_no_report_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.pulse_found |->
         !rsp_data_ff.pulse_complete && rsp_data_ff.pulse_number == '0 &&
         rsp_data_ff.report_time == '0 && rsp_data_ff.before_rise == '0 &&
         rsp_data_ff.after_rise == '0 && rsp_data_ff.before_fall == '0 &&
         rsp_data_ff.after_fall == '0)
      else $error("report fields set without a pulse report");
`endif

endmodule
